FILE: sv/blfa_pkg.sv
// ----------------------------------------------------------------------------
// blfa_pkg: shared types and constants for the battery level block
// Field widths, breakpoint register layout, and the sideband word that
// travels with each sample through the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package blfa_pkg;

  // default table size handed to the top level
  localparam int BREAKPOINTS_DEF = 8;

  // field widths
  localparam int ADC_W     = 16;  // sample and breakpoint ADC value
  localparam int LVL_RAW_W = 8;   // level byte in a breakpoint register
  localparam int LVL_W     = 7;   // saturated level, 0..100
  localparam int BP_W      = 24;  // one breakpoint register
  localparam int SEG_W     = 3;   // segment index
  localparam int CFG_IDX_W = 4;   // config register index

  // datapath widths
  localparam int DIFF_W = ADC_W + 1;       // signed ADC difference
  localparam int SPAN_W = LVL_W + 1;       // signed level span
  localparam int PROD_W = DIFF_W + SPAN_W; // signed product
  localparam int NUM_W  = 23;              // |product| <= 65535 * 100
  localparam int DEN_W  = ADC_W;           // |ADC span| <= 65535

  localparam logic [LVL_W-1:0] LEVEL_MAX = 7'd100;
  localparam logic [LVL_W-1:0] LEVEL_CRIT = 7'd1;

  // per-sample control carried alongside the division
  typedef struct packed {
    logic [LVL_W-1:0] fl;        // lower breakpoint level
    logic [LVL_W-1:0] top;       // level of entry 0, upper clamp
    logic [SEG_W-1:0] seg;       // chosen segment
    logic             den_zero;  // zero-width segment
    logic             neg;       // quotient sign is negative
  } side_t;

  // level byte saturated at 100
  function automatic logic [LVL_W-1:0] sat_level(input logic [LVL_RAW_W-1:0] v);
    logic [LVL_W-1:0] res;
    if (v > LVL_RAW_W'(LEVEL_MAX)) begin
      res = LEVEL_MAX;
    end else begin
      res = v[LVL_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: sv/blfa_front.sv
// ----------------------------------------------------------------------------
// blfa_front: segment search, operand fetch, product and sign split
// Five register stages: input, search, operand select with differences,
// signed multiply, magnitude and sign for the unsigned divider.
// ----------------------------------------------------------------------------
`default_nettype none

module blfa_front #(
  parameter int BREAKPOINTS = blfa_pkg::BREAKPOINTS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        in_valid,
  input  wire logic [blfa_pkg::ADC_W-1:0]                  in_sample,
  input  wire logic [BREAKPOINTS-1:0][blfa_pkg::BP_W-1:0]  bp,
  output logic                                             out_valid,
  output logic [blfa_pkg::NUM_W-1:0]                       out_num,
  output logic [blfa_pkg::DEN_W-1:0]                       out_den,
  output blfa_pkg::side_t                                  out_side
);

  localparam int IDX_W = (BREAKPOINTS > 1) ? $clog2(BREAKPOINTS) : 1;
  localparam int ADC_LSB = blfa_pkg::LVL_RAW_W;
  localparam logic [blfa_pkg::SEG_W-1:0] SEG_LAST = blfa_pkg::SEG_W'(BREAKPOINTS - 1);
  localparam logic [blfa_pkg::SEG_W-1:0] SEG_MAX  = blfa_pkg::SEG_W'(BREAKPOINTS - 2);

  // stage 0: input word
  logic                          v0_r;
  logic [blfa_pkg::ADC_W-1:0]    s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s0_r <= in_sample;
    end
  end

  // stage 1: segment search, all compares in parallel then priority pick
  logic [blfa_pkg::SEG_W-1:0] seg1_nxt;
  logic [blfa_pkg::SEG_W-1:0] seg1_r;
  logic [blfa_pkg::ADC_W-1:0] s1_r;
  logic                       v1_r;

  always_comb begin
    seg1_nxt = SEG_LAST;
    for (int i = BREAKPOINTS - 2; i >= 0; i--) begin
      if (s0_r >= bp[i][blfa_pkg::BP_W-1:ADC_LSB] ||
          s0_r >  bp[i+1][blfa_pkg::BP_W-1:ADC_LSB]) begin
        seg1_nxt = blfa_pkg::SEG_W'(i);
      end
    end
    // at or above the top, or below the bottom, take precedence
    if (s0_r >= bp[0][blfa_pkg::BP_W-1:ADC_LSB]) begin
      seg1_nxt = '0;
    end else if (s0_r < bp[BREAKPOINTS-1][blfa_pkg::BP_W-1:ADC_LSB]) begin
      seg1_nxt = SEG_LAST;
    end
    // the last entry has no lower partner
    if (seg1_nxt > SEG_MAX) begin
      seg1_nxt = SEG_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r   <= s0_r;
    seg1_r <= seg1_nxt;
  end

  // stage 2: fetch both breakpoints, form differences
  logic [blfa_pkg::SEG_W-1:0]          seg_lo;
  logic [blfa_pkg::BP_W-1:0]           up_bp;
  logic [blfa_pkg::BP_W-1:0]           lo_bp;
  logic [blfa_pkg::ADC_W-1:0]          ra;
  logic [blfa_pkg::ADC_W-1:0]          fa;
  logic [blfa_pkg::LVL_W-1:0]          rl;
  logic [blfa_pkg::LVL_W-1:0]          fl;
  logic signed [blfa_pkg::DIFF_W-1:0]  dsub2_nxt;
  logic signed [blfa_pkg::DIFF_W-1:0]  den2_nxt;
  logic signed [blfa_pkg::SPAN_W-1:0]  lspan2_nxt;
  blfa_pkg::side_t                     side2_nxt;

  logic signed [blfa_pkg::DIFF_W-1:0]  dsub2_r;
  logic signed [blfa_pkg::DIFF_W-1:0]  den2_r;
  logic signed [blfa_pkg::SPAN_W-1:0]  lspan2_r;
  blfa_pkg::side_t                     side2_r;
  logic                                v2_r;

  always_comb begin
    seg_lo     = seg1_r + 1'b1;
    up_bp      = bp[seg1_r[IDX_W-1:0]];
    lo_bp      = bp[seg_lo[IDX_W-1:0]];
    ra         = up_bp[blfa_pkg::BP_W-1:ADC_LSB];
    fa         = lo_bp[blfa_pkg::BP_W-1:ADC_LSB];
    rl         = blfa_pkg::sat_level(up_bp[ADC_LSB-1:0]);
    fl         = blfa_pkg::sat_level(lo_bp[ADC_LSB-1:0]);
    dsub2_nxt  = signed'({1'b0, s1_r}) - signed'({1'b0, fa});
    den2_nxt   = signed'({1'b0, ra}) - signed'({1'b0, fa});
    lspan2_nxt = signed'({1'b0, rl}) - signed'({1'b0, fl});
    side2_nxt.fl       = fl;
    side2_nxt.top      = blfa_pkg::sat_level(bp[0][ADC_LSB-1:0]);
    side2_nxt.seg      = seg1_r;
    side2_nxt.den_zero = (ra == fa);
    side2_nxt.neg      = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    dsub2_r  <= dsub2_nxt;
    den2_r   <= den2_nxt;
    lspan2_r <= lspan2_nxt;
    side2_r  <= side2_nxt;
  end

  // stage 3: signed product (sample - fa) * (rl - fl)
  logic signed [blfa_pkg::PROD_W-1:0]  prod3_nxt;
  logic signed [blfa_pkg::PROD_W-1:0]  prod3_r;
  logic signed [blfa_pkg::DIFF_W-1:0]  den3_r;
  blfa_pkg::side_t                     side3_r;
  logic                                v3_r;

  assign prod3_nxt = blfa_pkg::PROD_W'(dsub2_r) * blfa_pkg::PROD_W'(lspan2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod3_r <= prod3_nxt;
    den3_r  <= den2_r;
    side3_r <= side2_r;
  end

  // stage 4: magnitudes and quotient sign
  logic [blfa_pkg::PROD_W-1:0]  num_abs;
  logic [blfa_pkg::DIFF_W-1:0]  den_abs;
  blfa_pkg::side_t              side4_nxt;
  logic [blfa_pkg::NUM_W-1:0]   num4_r;
  logic [blfa_pkg::DEN_W-1:0]   den4_r;
  blfa_pkg::side_t              side4_r;
  logic                         v4_r;

  always_comb begin
    num_abs = prod3_r[blfa_pkg::PROD_W-1] ? unsigned'(-prod3_r) : unsigned'(prod3_r);
    den_abs = den3_r[blfa_pkg::DIFF_W-1] ? unsigned'(-den3_r) : unsigned'(den3_r);
    side4_nxt     = side3_r;
    side4_nxt.neg = prod3_r[blfa_pkg::PROD_W-1] ^ den3_r[blfa_pkg::DIFF_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    num4_r  <= num_abs[blfa_pkg::NUM_W-1:0];
    den4_r  <= den_abs[blfa_pkg::DEN_W-1:0];
    side4_r <= side4_nxt;
  end

  assign out_valid = v4_r;
  assign out_num   = num4_r;
  assign out_den   = den4_r;
  assign out_side  = side4_r;

endmodule

`default_nettype wire

FILE: sv/blfa_div.sv
// ----------------------------------------------------------------------------
// blfa_div: pipelined restoring divider, one quotient bit per stage
// Unsigned NUM_W by DEN_W division; the quotient bits shift into the
// numerator word. Sideband and valid travel with each stage.
// ----------------------------------------------------------------------------
`default_nettype none

module blfa_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [blfa_pkg::NUM_W-1:0]    in_num,
  input  wire logic [blfa_pkg::DEN_W-1:0]    in_den,
  input  wire blfa_pkg::side_t               in_side,
  output logic                               out_valid,
  output logic [blfa_pkg::NUM_W-1:0]         out_quo,
  output logic                               out_rem_nz,
  output blfa_pkg::side_t                    out_side
);

  localparam int STAGES = blfa_pkg::NUM_W;
  localparam int NW = blfa_pkg::NUM_W;
  localparam int DW = blfa_pkg::DEN_W;

  logic                  v_r    [STAGES];
  logic [DW-1:0]         rem_r  [STAGES];
  logic [NW-1:0]         nq_r   [STAGES];
  logic [DW-1:0]         d_r    [STAGES];
  blfa_pkg::side_t       side_r [STAGES];

  logic                  v_nxt    [STAGES];
  logic [DW-1:0]         rem_nxt  [STAGES];
  logic [NW-1:0]         nq_nxt   [STAGES];
  logic [DW-1:0]         d_nxt    [STAGES];
  blfa_pkg::side_t       side_nxt [STAGES];

  // each stage: shift in one numerator bit, subtract if it fits
  always_comb begin
    logic [DW-1:0]   rem_in;
    logic [NW-1:0]   nq_in;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            fits;
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        v_nxt[k]    = in_valid;
        rem_in      = '0;
        nq_in       = in_num;
        d_nxt[k]    = in_den;
        side_nxt[k] = in_side;
      end else begin
        v_nxt[k]    = v_r[k-1];
        rem_in      = rem_r[k-1];
        nq_in       = nq_r[k-1];
        d_nxt[k]    = d_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      trial      = {rem_in, nq_in[NW-1]};
      diff       = trial - {1'b0, d_nxt[k]};
      fits       = (trial >= {1'b0, d_nxt[k]});
      rem_nxt[k] = fits ? diff[DW-1:0] : trial[DW-1:0];
      nq_nxt[k]  = {nq_in[NW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STAGES; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        v_r[k] <= v_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      rem_r[k]  <= rem_nxt[k];
      nq_r[k]   <= nq_nxt[k];
      d_r[k]    <= d_nxt[k];
      side_r[k] <= side_nxt[k];
    end
  end

  assign out_valid  = v_r[STAGES-1];
  assign out_quo    = nq_r[STAGES-1];
  assign out_rem_nz = (rem_r[STAGES-1] != '0);
  assign out_side   = side_r[STAGES-1];

endmodule

`default_nettype wire

FILE: sv/blfa_fin.sv
// ----------------------------------------------------------------------------
// blfa_fin: floor correction, offset, clamp and result register
// Turns the unsigned quotient into a floored signed one, adds the lower
// level, clamps to [0, top] and flags a critical charge.
// ----------------------------------------------------------------------------
`default_nettype none

module blfa_fin (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [blfa_pkg::NUM_W-1:0]    in_quo,
  input  wire logic                          in_rem_nz,
  input  wire blfa_pkg::side_t               in_side,
  output logic                               out_valid,
  output logic [blfa_pkg::LVL_W-1:0]         out_level,
  output logic [blfa_pkg::SEG_W-1:0]         out_seg,
  output logic                               out_critical
);

  localparam int Q_W = blfa_pkg::NUM_W + 2;
  localparam int L_W = Q_W + 1;

  logic signed [Q_W-1:0]           q;
  logic signed [L_W-1:0]           lvl;
  logic signed [L_W-1:0]           top_s;
  logic [blfa_pkg::LVL_W-1:0]      level_nxt;

  logic                            valid_r;
  logic [blfa_pkg::LVL_W-1:0]      level_r;
  logic [blfa_pkg::SEG_W-1:0]      seg_r;
  logic                            crit_r;

  // floor: a negative quotient with a remainder steps one further down
  always_comb begin
    if (in_side.neg) begin
      q = -signed'({2'b00, in_quo} + Q_W'(in_rem_nz));
    end else begin
      q = signed'({2'b00, in_quo});
    end
    top_s = signed'(L_W'(in_side.top));
    lvl   = signed'(L_W'(in_side.fl)) + L_W'(q);
    if (in_side.den_zero) begin
      lvl = signed'(L_W'(in_side.fl));
    end
    if (lvl > top_s) begin
      level_nxt = in_side.top;
    end else if (lvl[L_W-1]) begin
      level_nxt = '0;
    end else begin
      level_nxt = lvl[blfa_pkg::LVL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    seg_r   <= in_side.seg;
    crit_r  <= (level_nxt <= blfa_pkg::LEVEL_CRIT);
  end

  assign out_valid    = valid_r;
  assign out_level    = level_r;
  assign out_seg      = seg_r;
  assign out_critical = crit_r;

endmodule

`default_nettype wire

FILE: sv/battery_level_from_adc_top.sv
// ----------------------------------------------------------------------------
// battery_level_from_adc_top: ADC sample to charge percentage
// Path from an accepted sample to the result strobe: 5 front stages, 23 divider
// stages, 1 result register. Throughput: one sample per cycle while busy is low;
// busy drops in the cycle after reset is released, results never stall.
// Reset: synchronous, clears the breakpoint table and all valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_from_adc_top #(
  parameter int BREAKPOINTS = blfa_pkg::BREAKPOINTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // sample channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [blfa_pkg::ADC_W-1:0]        in_sample,
  // result channel
  output logic                                   out_valid,
  output logic [blfa_pkg::LVL_W-1:0]             out_level_percent,
  output logic [blfa_pkg::SEG_W-1:0]             out_segment_index,
  output logic                                   out_critical,
  // register write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [blfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [blfa_pkg::BP_W-1:0]         cfg_data
);

  localparam int IDX_W = (BREAKPOINTS > 1) ? $clog2(BREAKPOINTS) : 1;

  logic                                        busy_r;
  logic [BREAKPOINTS-1:0][blfa_pkg::BP_W-1:0]  bp_r;
  logic                                        in_fire;

  logic                                        fr_valid;
  logic [blfa_pkg::NUM_W-1:0]                  fr_num;
  logic [blfa_pkg::DEN_W-1:0]                  fr_den;
  blfa_pkg::side_t                             fr_side;

  logic                                        dv_valid;
  logic [blfa_pkg::NUM_W-1:0]                  dv_quo;
  logic                                        dv_rem_nz;
  blfa_pkg::side_t                             dv_side;

  // busy only through reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign in_fire   = start && !busy_r;
  assign cfg_ready = 1'b1;

  // breakpoint table; writes past the table are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r <= '0;
    end else if (cfg_valid && cfg_ready &&
                 cfg_index < blfa_pkg::CFG_IDX_W'(BREAKPOINTS)) begin
      bp_r[cfg_index[IDX_W-1:0]] <= cfg_data;
    end
  end

  blfa_front #(
    .BREAKPOINTS (BREAKPOINTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_fire),
    .in_sample (in_sample),
    .bp        (bp_r),
    .out_valid (fr_valid),
    .out_num   (fr_num),
    .out_den   (fr_den),
    .out_side  (fr_side)
  );

  blfa_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (fr_valid),
    .in_num     (fr_num),
    .in_den     (fr_den),
    .in_side    (fr_side),
    .out_valid  (dv_valid),
    .out_quo    (dv_quo),
    .out_rem_nz (dv_rem_nz),
    .out_side   (dv_side)
  );

  blfa_fin u_fin (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (dv_valid),
    .in_quo       (dv_quo),
    .in_rem_nz    (dv_rem_nz),
    .in_side      (dv_side),
    .out_valid    (out_valid),
    .out_level    (out_level_percent),
    .out_seg      (out_segment_index),
    .out_critical (out_critical)
  );

endmodule

`default_nettype wire

FILE: sv/blfa_chk.sv
// ----------------------------------------------------------------------------
// blfa_chk: port-level checks for the battery level block
// Watches the result word and the busy line; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module blfa_chk #(
  parameter int BREAKPOINTS = blfa_pkg::BREAKPOINTS_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            busy,
  input wire logic                            out_valid,
  input wire logic [blfa_pkg::LVL_W-1:0]      out_level_percent,
  input wire logic [blfa_pkg::SEG_W-1:0]      out_segment_index,
  input wire logic                            out_critical
);

  localparam logic [blfa_pkg::SEG_W-1:0] SEG_MAX = blfa_pkg::SEG_W'(BREAKPOINTS - 2);

  // block takes samples every cycle once out of reset
  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset");

  // level never passes full charge
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level_percent <= blfa_pkg::LEVEL_MAX)
    else $error("level above 100");

  // critical flag agrees with the level
  a_crit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_critical == (out_level_percent <= blfa_pkg::LEVEL_CRIT))
    else $error("critical flag mismatch");

  // segment always has a lower partner
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_segment_index <= SEG_MAX)
    else $error("segment index past the table");

endmodule

bind battery_level_from_adc_top blfa_chk #(
  .BREAKPOINTS (BREAKPOINTS)
) u_blfa_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_level_percent (out_level_percent),
  .out_segment_index (out_segment_index),
  .out_critical      (out_critical)
);

`default_nettype wire

FILE: verif/battery_level_from_adc_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: battery level from ADC sample, self-checking
// Loads breakpoint tables through the register write channel. Each table
// setting is followed by a batch of samples. A local model of the interpolation
// predicts every result word when its sample is accepted, and the result
// stream is checked in order, field by field. A short directed part covers
// the reset table, exact breakpoint hits, zero-width and unordered segments and
// saturated levels. The random part then varies the tables, the samples and the
// gaps on the sample channel.
// ----------------------------------------------------------------------------

module testbench;

  // package constants used throughout
  localparam int ADC_W     = blfa_pkg::ADC_W;
  localparam int LVL_RAW_W = blfa_pkg::LVL_RAW_W;
  localparam int LVL_W     = blfa_pkg::LVL_W;
  localparam int BP_W      = blfa_pkg::BP_W;
  localparam int SEG_W     = blfa_pkg::SEG_W;
  localparam int CFG_IDX_W = blfa_pkg::CFG_IDX_W;
  localparam logic [LVL_W-1:0] LEVEL_MAX = blfa_pkg::LEVEL_MAX;

  localparam int NUM_BP      = blfa_pkg::BREAKPOINTS_DEF;
  localparam int BP_REG_BASE = 0;                      // breakpoint_0 index
  localparam int CFG_TOP_IDX = (1 << CFG_IDX_W) - 1;   // highest decodable index
  localparam int GAP_LIGHT   = 8;
  localparam int GAP_HEAVY   = 70;
  localparam int GAP_NONE    = 0;
  localparam int ITEMS_PER_TABLE = 30;
  localparam int TABLES_PER_PHASE = 6;

  // directed tables, entry 0 in the low bits
  // descending, entry 0 level byte above 100, entries 4 and 5 share an ADC value
  localparam logic [NUM_BP*BP_W-1:0] DESC_TABLE = {
    24'h100000, 24'h40000A, 24'h800014, 24'h80001E,
    24'hA00032, 24'hC00046, 24'hE0005A, 24'hF000FF
  };
  // unordered: rising and falling spans, a level byte above 100 in the middle
  localparam logic [NUM_BP*BP_W-1:0] MIXED_TABLE = {
    24'h080000, 24'hF00028, 24'h7000C8, 24'h900005,
    24'h200064, 24'h500032, 24'h300014, 24'h10000A
  };

  typedef enum int {TAB_ORDERED, TAB_EXTREME, TAB_RANDOM} table_kind_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [SEG_W-1:0] seg;
    logic             crit;
  } level_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [ADC_W-1:0] in_sample = '0;
  logic busy;
  logic out_valid;
  logic [LVL_W-1:0] out_level_percent;
  logic [SEG_W-1:0] out_segment_index;
  logic out_critical;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BP_W-1:0] cfg_data = '0;

  // local copy of the breakpoint registers
  logic [BP_W-1:0] bp_table [NUM_BP];

  logic [ADC_W-1:0] sample_backlog [$];
  level_word_t      level_fifo [$];
  level_word_t      want;
  int               samples_owed = 0;
  int               gap_pct = GAP_NONE;
  int               mismatch_count = 0;
  bit               word_taken = 1'b0;

  battery_level_from_adc_top #(
    .BREAKPOINTS(NUM_BP)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_level_percent (out_level_percent),
    .out_segment_index (out_segment_index),
    .out_critical      (out_critical),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #6 clk = ~clk;

  // interpolated level for one sample under the current table
  function automatic level_word_t predict_level(input logic [ADC_W-1:0] s);
    longint adc_at [NUM_BP];
    longint lvl_at [NUM_BP];
    longint smp, num, den, quo, lvl;
    int i, seg;
    bit found;
    level_word_t w;
    smp = s;
    for (i = 0; i < NUM_BP; i++) begin
      adc_at[i] = bp_table[i][BP_W-1:LVL_RAW_W];
      lvl_at[i] = (bp_table[i][LVL_RAW_W-1:0] > LEVEL_MAX) ?
                  LEVEL_MAX : bp_table[i][LVL_RAW_W-1:0];
    end
    // scan from the top; an exact hit on a lower point falls to the next segment
    seg = NUM_BP;
    found = 1'b0;
    for (i = 0; i < NUM_BP && !found; i++) begin
      if (smp >= adc_at[i]) begin
        seg = i;
        found = 1'b1;
      end else if (smp < adc_at[NUM_BP-1]) begin
        seg = NUM_BP - 1;
        found = 1'b1;
      end else if (i + 1 < NUM_BP && smp <= adc_at[i] && smp > adc_at[i+1]) begin
        seg = i;
        found = 1'b1;
      end
    end
    // last entry has no lower partner, no hit at all: use the last segment
    if (seg > NUM_BP - 2) seg = NUM_BP - 2;
    den = adc_at[seg] - adc_at[seg+1];
    if (den == 0) begin
      lvl = lvl_at[seg+1];
    end else begin
      num = (smp - adc_at[seg+1]) * (lvl_at[seg] - lvl_at[seg+1]);
      quo = num / den;
      if (num % den != 0 && ((num < 0) != (den < 0))) quo = quo - 1;
      lvl = lvl_at[seg+1] + quo;
    end
    if (lvl > lvl_at[0]) lvl = lvl_at[0];
    if (lvl < 0) lvl = 0;
    w.level = LVL_W'(lvl);
    w.seg   = SEG_W'(seg);
    w.crit  = (lvl <= 1);
    return w;
  endfunction

  // sample driver: next word from the backlog, random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (sample_backlog.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
        start     <= 1'b1;
        in_sample <= sample_backlog.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor, then prediction for the word accepted at this edge
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (level_fifo.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected: level %0d seg %0d crit %0b",
                 $time, out_level_percent, out_segment_index, out_critical);
      end else begin
        want = level_fifo.pop_front();
        if (out_level_percent !== want.level || out_segment_index !== want.seg ||
            out_critical !== want.crit) begin
          mismatch_count++;
          $display("%0t: expected level %0d seg %0d crit %0b, got level %0d seg %0d crit %0b",
                   $time, want.level, want.seg, want.crit,
                   out_level_percent, out_segment_index, out_critical);
        end
      end
    end
    word_taken = rst_n && start && !busy;
    if (word_taken) begin
      level_fifo.push_back(predict_level(in_sample));
      samples_owed--;
    end
  end

  // one register write; out-of-range indexes leave the table alone
  task automatic cfg_write(input int idx, input logic [BP_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_BP) bp_table[idx] = data;
  endtask

  task automatic cfg_done;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_packed(input logic [NUM_BP*BP_W-1:0] tab);
    int i;
    for (i = 0; i < NUM_BP; i++) cfg_write(BP_REG_BASE + i, tab[i*BP_W +: BP_W]);
  endtask

  task automatic load_table(input table_kind_t kind);
    int i, a, l;
    a = 0;
    l = 0;
    for (i = 0; i < NUM_BP; i++) begin
      case (kind)
        TAB_RANDOM: begin
          a = $urandom_range(65535, 0);
          l = $urandom_range(255, 0);
        end
        TAB_EXTREME: begin
          a = (i == NUM_BP - 1) ? 0 : 65535 - i * 9362;
          l = (i == 0) ? 255 : 100 - (i * 100) / (NUM_BP - 1);
        end
        default: begin
          if (i == 0) begin
            a = $urandom_range(65535, 16000);
            l = $urandom_range(255, 40);
          end else begin
            // now and then a zero-width segment
            if ($urandom_range(7, 0) != 0) a -= $urandom_range(9000, 1);
            if (a < 0) a = 0;
            l -= $urandom_range(20, 0);
            if (l < 0) l = 0;
          end
        end
      endcase
      cfg_write(BP_REG_BASE + i, {a[ADC_W-1:0], l[LVL_RAW_W-1:0]});
    end
    if ($urandom_range(2, 0) == 0) cfg_write($urandom_range(CFG_TOP_IDX, NUM_BP), BP_W'($urandom));
    cfg_done();
  endtask

  task automatic queue_sample(input logic [ADC_W-1:0] v);
    sample_backlog.push_back(v);
    samples_owed++;
  endtask

  // mostly near a breakpoint, otherwise anywhere
  function automatic logic [ADC_W-1:0] pick_sample();
    int k, v;
    if ($urandom_range(9, 0) < 6) begin
      k = $urandom_range(NUM_BP - 1, 0);
      v = int'(bp_table[k][BP_W-1:LVL_RAW_W]) + int'($urandom_range(4, 0)) - 2;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
    end else begin
      v = $urandom_range(65535, 0);
    end
    return ADC_W'(v);
  endfunction

  task automatic wait_results_done;
    do @(negedge clk); while (samples_owed != 0 || level_fifo.size() != 0);
  endtask

  initial begin
    int ph, t, n;
    table_kind_t kind;
    foreach (bp_table[i]) bp_table[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset table: all zero
    queue_sample(16'h0000);
    queue_sample(16'hFFFF);
    wait_results_done();

    // descending table, plus writes to indexes past the table
    load_packed(DESC_TABLE);
    cfg_write(NUM_BP, '1);
    cfg_write(CFG_TOP_IDX, 24'h123456);
    cfg_done();
    queue_sample(16'hFFFF);
    queue_sample(16'hF000);
    queue_sample(16'hE000);
    queue_sample(16'hDFFF);
    queue_sample(16'hA001);
    queue_sample(16'h8000);
    queue_sample(16'h9000);
    queue_sample(16'h4000);
    queue_sample(16'h1000);
    queue_sample(16'h0800);
    queue_sample(16'h0000);
    wait_results_done();

    // unordered table: negative spans, clamps at both ends
    load_packed(MIXED_TABLE);
    cfg_done();
    queue_sample(16'h0000);
    queue_sample(16'h0FFF);
    queue_sample(16'h2000);
    queue_sample(16'h4000);
    queue_sample(16'h6000);
    queue_sample(16'h8000);
    queue_sample(16'hFFFF);
    wait_results_done();

    // random tables and samples under three gap settings
    for (ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? GAP_LIGHT : (ph == 1) ? GAP_HEAVY : GAP_NONE;
      for (t = 0; t < TABLES_PER_PHASE; t++) begin
        kind = (t == 0) ? TAB_EXTREME : (t == TABLES_PER_PHASE - 1) ? TAB_RANDOM : TAB_ORDERED;
        load_table(kind);
        for (n = 0; n < ITEMS_PER_TABLE; n++) queue_sample(pick_sample());
        wait_results_done();
      end
    end

    // let the pipeline run dry before the verdict
    repeat (40) @(posedge clk);
    if (level_fifo.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected words never arrived", $time, level_fifo.size());
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
